FILE: rtl/cfnp_pkg.sv
// cfnp_pkg: constants and field codes for the cube face normal packer.
// No dependencies; imported by cube_face_normal_packer_unit.
`default_nettype none

package cfnp_pkg;

  // Component width default and fixed field widths
  localparam int unsigned CFNP_COMPONENT_BITS = 16;
  localparam int unsigned SHADE_BITS          = 16;
  localparam int unsigned SHADE_FRAC_BITS     = 15;   // shade = level / 2^15
  localparam int unsigned SHADE_CODE_BITS     = 7;
  localparam int unsigned CODE_BITS           = 11;   // u and v code width
  localparam int unsigned FACE_BITS           = 2;
  localparam int unsigned WORD_BITS           = 32;

  localparam logic [CODE_BITS-1:0]       CODE_SCALE     = 11'h7FF;  // 2^11 - 1
  localparam logic [SHADE_CODE_BITS-1:0] SHADE_CODE_MAX = 7'h7F;    // 127

  // Dominant axis codes
  localparam logic [FACE_BITS-1:0] FACE_X = 2'd0;
  localparam logic [FACE_BITS-1:0] FACE_Y = 2'd1;
  localparam logic [FACE_BITS-1:0] FACE_Z = 2'd2;

endpackage : cfnp_pkg

`default_nettype wire

FILE: rtl/cube_face_normal_packer_unit.sv
// cube_face_normal_packer_unit: packs a normal and a shade level into one 32-bit word.
// Depends on cfnp_pkg for field widths, scale constants and face codes.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with normal_x_i, normal_y_i, normal_z_i
//   (signed, COMPONENT_BITS wide) and shade_level_i (unsigned 16 bits).
//   Output channel: out_valid_o / out_stall_i with packed_word_o laid out as
//   sign[31], face[30:29], u[28:18], v[17:7], shade[6:0].
//   A transfer happens on a rising edge where valid is high and stall is low.
//
//   There are 14 register stages from input transfer to output valid; throughput
//   is one item per cycle while the receiver does not stall. The two restoring
//   dividers (u and v) resolve one quotient bit per stage over 11 stages after
//   three front stages: axis select, offset add, and scale by 2047.
//
//   The whole pipe advances under one enable. When the output holds a result and
//   the receiver stalls, every stage freezes and in_stall_o rises in the same
//   cycle, so nothing is dropped or repeated; the output word stays stable.
//   Reset clears all stage valid bits; payload registers are not reset.
//   An all-zero normal gives face x, sign 0, u = v = 0.
`default_nettype none

module cube_face_normal_packer_unit #(
  parameter int unsigned COMPONENT_BITS = cfnp_pkg::CFNP_COMPONENT_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [COMPONENT_BITS-1:0]  normal_x_i,
  input  wire logic signed [COMPONENT_BITS-1:0]  normal_y_i,
  input  wire logic signed [COMPONENT_BITS-1:0]  normal_z_i,
  input  wire logic [cfnp_pkg::SHADE_BITS-1:0]   shade_level_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [cfnp_pkg::WORD_BITS-1:0]         packed_word_o
);

  import cfnp_pkg::*;

  localparam int unsigned N      = COMPONENT_BITS;
  localparam int unsigned DW     = N + 1;              // 2d and a+d, up to 2^N
  localparam int unsigned W      = N + CODE_BITS + 1;  // dividend / remainder
  localparam int unsigned STAGES = CODE_BITS;          // one quotient bit each
  localparam int unsigned PROD_W = SHADE_BITS + SHADE_CODE_BITS;

  // Global advance: stall only while a finished word waits at the output.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------------------------------------------------------------
  // Stage 1: magnitudes, dominant axis, sign, following axes, shade code
  // ---------------------------------------------------------------------
  logic [N-1:0]               mag_x, mag_y, mag_z;
  logic [N-1:0]               dom_d;
  logic [FACE_BITS-1:0]       dom_face;
  logic                       dom_sign;
  logic signed [N-1:0]        fol_a1, fol_a2;
  logic [PROD_W-1:0]          shade_prod;
  logic [PROD_W-SHADE_FRAC_BITS-1:0] shade_raw;
  logic [SHADE_CODE_BITS-1:0] shade_code;

  // |x| fits in N bits unsigned, including the most negative value
  assign mag_x = normal_x_i[N-1] ? N'(-normal_x_i) : N'(normal_x_i);
  assign mag_y = normal_y_i[N-1] ? N'(-normal_y_i) : N'(normal_y_i);
  assign mag_z = normal_z_i[N-1] ? N'(-normal_z_i) : N'(normal_z_i);

  always_comb begin
    logic [N-1:0] d_xy;
    logic [FACE_BITS-1:0] f_xy;
    // ties favor x, then y
    if (mag_y > mag_x) begin
      d_xy = mag_y;
      f_xy = FACE_Y;
    end else begin
      d_xy = mag_x;
      f_xy = FACE_X;
    end
    if (mag_z > d_xy) begin
      dom_d    = mag_z;
      dom_face = FACE_Z;
    end else begin
      dom_d    = d_xy;
      dom_face = f_xy;
    end
    case (dom_face)
      FACE_Y: begin
        dom_sign = normal_y_i[N-1];
        fol_a1   = normal_z_i;
        fol_a2   = normal_x_i;
      end
      FACE_Z: begin
        dom_sign = normal_z_i[N-1];
        fol_a1   = normal_x_i;
        fol_a2   = normal_y_i;
      end
      default: begin
        dom_sign = normal_x_i[N-1];
        fol_a1   = normal_y_i;
        fol_a2   = normal_z_i;
      end
    endcase
  end

  // shade code = min(floor(level * 127 / 2^15), 127)
  assign shade_prod = PROD_W'(shade_level_i) * PROD_W'(SHADE_CODE_MAX);
  assign shade_raw  = shade_prod[PROD_W-1:SHADE_FRAC_BITS];
  assign shade_code = (shade_raw > {1'b0, SHADE_CODE_MAX}) ? SHADE_CODE_MAX
                                                          : shade_raw[SHADE_CODE_BITS-1:0];

  logic                       s1_valid_q;
  logic                       s1_sign_q;
  logic [FACE_BITS-1:0]       s1_face_q;
  logic [N-1:0]               s1_d_q;
  logic signed [N-1:0]        s1_a1_q, s1_a2_q;
  logic [SHADE_CODE_BITS-1:0] s1_shade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sign_q  <= dom_sign;
      s1_face_q  <= dom_face;
      s1_d_q     <= dom_d;
      s1_a1_q    <= fol_a1;
      s1_a2_q    <= fol_a2;
      s1_shade_q <= shade_code;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: offset a + d (always 0 .. 2d), divisor 2d, zero flag
  // ---------------------------------------------------------------------
  logic signed [N+1:0] sum1, sum2;
  assign sum1 = $signed({{2{s1_a1_q[N-1]}}, s1_a1_q}) + $signed({2'b00, s1_d_q});
  assign sum2 = $signed({{2{s1_a2_q[N-1]}}, s1_a2_q}) + $signed({2'b00, s1_d_q});

  logic                       s2_valid_q;
  logic                       s2_sign_q;
  logic [FACE_BITS-1:0]       s2_face_q;
  logic [DW-1:0]              s2_num1_q, s2_num2_q, s2_dd_q;
  logic                       s2_zero_q;
  logic [SHADE_CODE_BITS-1:0] s2_shade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sign_q  <= s1_sign_q;
      s2_face_q  <= s1_face_q;
      s2_num1_q  <= sum1[DW-1:0];
      s2_num2_q  <= sum2[DW-1:0];
      s2_dd_q    <= {s1_d_q, 1'b0};
      s2_zero_q  <= (s1_d_q == '0);
      s2_shade_q <= s1_shade_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3 (divider entry): dividend = num * 2047 = (num << 11) - num
  // Divider stages 1..STAGES: restoring, one quotient bit per stage, MSB first.
  // Quotient never exceeds 2047 since num <= 2d.
  // ---------------------------------------------------------------------
  logic [W-1:0] num1_x, num2_x;
  assign num1_x = (W'(s2_num1_q) << CODE_BITS) - W'(s2_num1_q);
  assign num2_x = (W'(s2_num2_q) << CODE_BITS) - W'(s2_num2_q);

  logic                       dv_valid_q [STAGES+1];
  logic                       dv_sign_q  [STAGES+1];
  logic [FACE_BITS-1:0]       dv_face_q  [STAGES+1];
  logic [DW-1:0]              dv_dd_q    [STAGES+1];
  logic                       dv_zero_q  [STAGES+1];
  logic [SHADE_CODE_BITS-1:0] dv_shade_q [STAGES+1];
  logic [W-1:0]               dv_rem1_q  [STAGES+1];
  logic [W-1:0]               dv_rem2_q  [STAGES+1];
  logic [CODE_BITS-1:0]       dv_q1_q    [STAGES+1];
  logic [CODE_BITS-1:0]       dv_q2_q    [STAGES+1];

  // per-stage trial subtract
  logic [W-1:0] rem1_d [STAGES];
  logic [W-1:0] rem2_d [STAGES];
  logic         bit1_d [STAGES];
  logic         bit2_d [STAGES];

  always_comb begin
    logic [W-1:0] shifted;
    for (int j = 0; j < STAGES; j++) begin
      shifted   = W'(dv_dd_q[j]) << (STAGES - 1 - j);
      bit1_d[j] = (dv_rem1_q[j] >= shifted);
      bit2_d[j] = (dv_rem2_q[j] >= shifted);
      rem1_d[j] = bit1_d[j] ? (dv_rem1_q[j] - shifted) : dv_rem1_q[j];
      rem2_d[j] = bit2_d[j] ? (dv_rem2_q[j] - shifted) : dv_rem2_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= STAGES; j++) begin
        dv_valid_q[j] <= 1'b0;
      end
    end else if (adv) begin
      dv_valid_q[0] <= s2_valid_q;
      for (int j = 0; j < STAGES; j++) begin
        dv_valid_q[j+1] <= dv_valid_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_sign_q[0]  <= s2_sign_q;
      dv_face_q[0]  <= s2_face_q;
      dv_dd_q[0]    <= s2_dd_q;
      dv_zero_q[0]  <= s2_zero_q;
      dv_shade_q[0] <= s2_shade_q;
      dv_rem1_q[0]  <= num1_x;
      dv_rem2_q[0]  <= num2_x;
      dv_q1_q[0]    <= '0;
      dv_q2_q[0]    <= '0;
      for (int j = 0; j < STAGES; j++) begin
        dv_sign_q[j+1]  <= dv_sign_q[j];
        dv_face_q[j+1]  <= dv_face_q[j];
        dv_dd_q[j+1]    <= dv_dd_q[j];
        dv_zero_q[j+1]  <= dv_zero_q[j];
        dv_shade_q[j+1] <= dv_shade_q[j];
        dv_rem1_q[j+1]  <= rem1_d[j];
        dv_rem2_q[j+1]  <= rem2_d[j];
        dv_q1_q[j+1]    <= {dv_q1_q[j][CODE_BITS-2:0], bit1_d[j]};
        dv_q2_q[j+1]    <= {dv_q2_q[j][CODE_BITS-2:0], bit2_d[j]};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output: last divider stage is the output register
  // ---------------------------------------------------------------------
  logic [CODE_BITS-1:0] code_u, code_v;
  // zero vector: divisor is zero, force both codes to zero
  assign code_u = dv_zero_q[STAGES] ? '0 : dv_q1_q[STAGES];
  assign code_v = dv_zero_q[STAGES] ? '0 : dv_q2_q[STAGES];

  assign out_valid_o   = dv_valid_q[STAGES];
  assign packed_word_o = {dv_sign_q[STAGES], dv_face_q[STAGES], code_u, code_v,
                          dv_shade_q[STAGES]};

endmodule : cube_face_normal_packer_unit

`default_nettype wire
